>>> design/clti_pkg.sv
// shared types, register map and codes for the core-local timer interrupter
`timescale 1ns / 1ps
`default_nettype none
package clti_pkg;

	// number of harts served
	localparam int HART_COUNT = 2;
	localparam int IRQ_W = 2;

	// item kinds
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_WRITE = 2'd2;
	localparam logic [1:0] FUNC_NONE  = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_ACCESS = 2'd1;
	localparam logic [1:0] ST_UNMAPPED   = 2'd2;
	localparam logic [1:0] ST_TIME_WRITE = 2'd3;

	// register map
	localparam logic [15:0] ADDR_CMP_BASE = 16'h4000;
	localparam logic [15:0] ADDR_CMP_END  = 16'h4010;
	localparam logic [15:0] ADDR_TIME_LO  = 16'hbff8;
	localparam logic [15:0] ADDR_TIME_HI  = 16'hbffc;
	localparam logic [3:0]  ACCESS_WORD   = 4'd4;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] bus_address;
		logic [3:0]  access_size;
		logic [31:0] write_data;
	} item_t;

	typedef struct packed {
		logic [31:0]      read_data;
		logic [1:0]       status;
		logic [IRQ_W-1:0] soft_irqs;
		logic [IRQ_W-1:0] timer_irqs;
	} result_t;

endpackage
`default_nettype wire

>>> design/core_local_timer_interrupter.sv
// top level of the core-local timer interrupter
// Use: one item channel (item_valid, item_stall, item) carries a time tick, a
// bus read or a bus write; one result channel (result_valid, result_stall,
// result) returns exactly one beat per item with read data, status and the
// software and timer interrupt levels of each hart after that item.
// A beat moves when valid is high and stall is low.
// Path: an accepted item sits in the input register while decode, state
// update and the 64-bit time compare run in one pass from it into the
// result register.
// Throughput: one item per cycle while result_stall is low, set by that single
// pass between the input register and the result register.
// Reset: arst_n clears time, compare values, software levels and timer
// arming, and empties both registers.
// Stall: while result_stall holds a result, the staged item waits and
// item_stall rises once the input register is full; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none
module core_local_timer_interrupter (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire clti_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output clti_pkg::result_t      result
);
	import clti_pkg::*;

	logic    advance;
	logic    valid_s1;
	logic    fire;
	item_t   item_s1;
	result_t result_d;

	// the staged item is processed when the result register can take it
	assign fire = valid_s1 && advance;

	clti_input_reg u_input_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.advance    (advance),
		.item_stall (item_stall),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	clti_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item_s1 (item_s1),
		.result  (result_d)
	);

	clti_result_reg u_result_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (valid_s1),
		.result_d     (result_d),
		.result_stall (result_stall),
		.advance      (advance),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
`default_nettype wire

>>> design/clti_input_reg.sv
// input stage register holding one accepted item
`timescale 1ns / 1ps
`default_nettype none
module clti_input_reg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	input  wire clti_pkg::item_t item,
	input  wire logic           advance,
	output logic                item_stall,
	output logic                valid_s1,
	output clti_pkg::item_t     item_s1
);
	import clti_pkg::*;

	logic load;

	// take a new beat when the stage is empty or moving on
	assign item_stall = valid_s1 && !advance;
	assign load = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= item_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

endmodule
`default_nettype wire

>>> design/clti_regs.sv
// timer, compare and software interrupt state with the register access decode
`timescale 1ns / 1ps
`default_nettype none
module clti_regs (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire clti_pkg::item_t  item_s1,
	output clti_pkg::result_t     result
);
	import clti_pkg::*;

	logic [63:0]           time_q, time_d;
	logic [63:0]           cmp_q [HART_COUNT];
	logic [63:0]           cmp_d [HART_COUNT];
	logic [HART_COUNT-1:0] soft_q, soft_d;
	logic [HART_COUNT-1:0] armed_q, armed_d;

	logic        is_bus;
	logic        is_write;
	logic        good_access;
	logic        hit;
	logic [13:0] soft_word;
	logic        cmp_hart;
	logic        cmp_high;
	logic [31:0] rd;
	logic [1:0]  st;
	logic [IRQ_W-1:0] soft_out;
	logic [IRQ_W-1:0] timer_out;

	assign soft_word = item_s1.bus_address[15:2];
	assign cmp_hart  = item_s1.bus_address[3];
	assign cmp_high  = item_s1.bus_address[2];
	assign good_access = (item_s1.access_size == ACCESS_WORD)
		&& (item_s1.bus_address[1:0] == 2'b00);

	// next state and read data for the item in the stage
	always_comb begin
		time_d  = time_q;
		cmp_d   = cmp_q;
		soft_d  = soft_q;
		armed_d = armed_q;
		rd      = '0;
		st      = ST_OK;
		hit     = 1'b0;
		is_bus  = 1'b0;
		is_write = 1'b0;
		unique case (item_s1.func)
			FUNC_TICK: begin
				time_d = time_q + 64'd1;
			end
			FUNC_READ: begin
				is_bus = 1'b1;
			end
			FUNC_WRITE: begin
				is_bus   = 1'b1;
				is_write = 1'b1;
			end
			default: begin
				is_bus = 1'b0;
			end
		endcase
		if (is_bus) begin
			if (!good_access) begin
				st = ST_BAD_ACCESS;
			end else if (item_s1.bus_address < ADDR_CMP_BASE) begin
				// software interrupt words
				for (int h = 0; h < HART_COUNT; h++) begin
					if (soft_word == 14'(h)) begin
						hit = 1'b1;
						if (is_write) begin
							soft_d[h] = item_s1.write_data[0];
						end else begin
							rd = {31'd0, soft_q[h]};
						end
					end
				end
				if (!hit) begin
					st = ST_UNMAPPED;
				end
			end else if (item_s1.bus_address < ADDR_CMP_END) begin
				// compare halves, a write arms the timer
				for (int h = 0; h < HART_COUNT; h++) begin
					if (cmp_hart == 1'(h)) begin
						hit = 1'b1;
						if (is_write) begin
							if (cmp_high) begin
								cmp_d[h][63:32] = item_s1.write_data;
							end else begin
								cmp_d[h][31:0] = item_s1.write_data;
							end
							armed_d[h] = 1'b1;
						end else begin
							rd = cmp_high ? cmp_q[h][63:32] : cmp_q[h][31:0];
						end
					end
				end
				if (!hit) begin
					st = ST_UNMAPPED;
				end
			end else if (item_s1.bus_address == ADDR_TIME_LO
				|| item_s1.bus_address == ADDR_TIME_HI) begin
				if (is_write) begin
					st = ST_TIME_WRITE;
				end else begin
					rd = (item_s1.bus_address == ADDR_TIME_HI) ? time_q[63:32]
						: time_q[31:0];
				end
			end else begin
				st = ST_UNMAPPED;
			end
		end
	end

	// interrupt levels after this item
	always_comb begin
		soft_out  = '0;
		timer_out = '0;
		for (int h = 0; h < HART_COUNT; h++) begin
			soft_out[h]  = soft_d[h];
			timer_out[h] = armed_d[h] && (time_d >= cmp_d[h]);
		end
	end

	assign result.read_data  = rd;
	assign result.status     = st;
	assign result.soft_irqs  = soft_out;
	assign result.timer_irqs = timer_out;

	// architectural state, updated as the item leaves the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q  <= '0;
			soft_q  <= '0;
			armed_q <= '0;
			for (int h = 0; h < HART_COUNT; h++) begin
				cmp_q[h] <= '0;
			end
		end else if (fire) begin
			time_q  <= time_d;
			soft_q  <= soft_d;
			armed_q <= armed_d;
			cmp_q   <= cmp_d;
		end
	end

`ifndef SYNTHESIS
	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(st != ST_OK) |-> (rd == 32'd0))
		else $error("read data not zero on an error status");
	a_tick_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.func == FUNC_TICK) |=> (time_q == $past(time_q) + 64'd1))
		else $error("tick did not advance time");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> ($stable(time_q) && $stable(soft_q) && $stable(armed_q)))
		else $error("state changed without an item");
`endif

endmodule
`default_nettype wire

>>> design/clti_result_reg.sv
// output register holding one finished result until it is taken
`timescale 1ns / 1ps
`default_nettype none
module clti_result_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire clti_pkg::result_t result_d,
	input  wire logic              result_stall,
	output logic                   advance,
	output logic                   result_valid,
	output clti_pkg::result_t      result
);
	import clti_pkg::*;

	// room for a new result when empty or when the current beat is taken
	assign advance = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load) begin
			result <= result_d;
		end
	end

endmodule
`default_nettype wire
